FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the convex polygon area RTL.
// Included by the modules that check their own internal invariants.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CPA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("convex polygon area: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CPA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("convex polygon area: next-cycle check failed");

`endif

FILE: rtl/core/cpa_pkg.sv
// Package for the convex polygon area block: widths, item types and status codes.
// No dependencies; every module of the block imports it.
`default_nettype none

package cpa_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = 51;
  localparam int AREA_W      = 50;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] STATUS_VALID    = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } cpa_vertex_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_doubled;
    logic [1:0]        status;
  } cpa_result_t;

  // What the back end has to do with one vertex.
  typedef struct packed {
    logic do_term;
    logic do_cross;
    logic set_ref;
    logic wrap;
    logic over;
    logic last;
  } cpa_flags_t;

  // Edge vectors of one triple: d1 = c - b, d2 = a - b.
  typedef struct packed {
    diff_t d1x;
    diff_t d1y;
    diff_t d2x;
    diff_t d2y;
  } cpa_cross_ops_t;

  typedef struct packed {
    cpa_flags_t     flags;
    diff_t          term_a;
    diff_t          term_b;
    diff_t          close_a;
    diff_t          close_b;
    cpa_cross_ops_t cm;
    cpa_cross_ops_t w1;
    cpa_cross_ops_t w2;
  } cpa_op_t;

  function automatic diff_t widen(coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cpa_front.sv
// Front end of the convex polygon area block: takes vertices, tracks the vertex
// window and forms the operand differences for the back end. Uses cpa_pkg.
`default_nettype none

module cpa_front #(
  parameter int unsigned MAX_VERTICES = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vertex_valid,
  input  cpa_pkg::cpa_vertex_t vertex,
  output logic                 vertex_stall,
  input  logic                 queue_full,
  output logic                 push,
  output cpa_pkg::cpa_op_t     push_op
);
  import cpa_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(MAX_VERTICES + 1);

  logic [CNT_W-1:0] vertex_count;
  coord_t first_x, first_y, second_x, second_y;
  coord_t older_x, older_y, previous_x, previous_y;

  logic   taken;
  logic   idx_zero, idx_one, idx_two, idx_ge2;
  diff_t  x, y, fx, fy;

  assign vertex_stall = queue_full;
  assign push         = vertex_valid && !queue_full;

  always_comb begin
    taken    = vertex_count < MAX_CNT;
    idx_zero = vertex_count == '0;
    idx_one  = vertex_count == CNT_W'(1);
    idx_two  = vertex_count == CNT_W'(2);
    idx_ge2  = vertex_count >= CNT_W'(2);
    x        = widen(vertex.vertex_x);
    y        = widen(vertex.vertex_y);
    // The first vertex closes onto itself when it is also the last one.
    fx       = idx_zero ? x : widen(first_x);
    fy       = idx_zero ? y : widen(first_y);

    push_op.flags.do_term  = taken && !idx_zero;
    push_op.flags.do_cross = taken && idx_ge2;
    push_op.flags.set_ref  = taken && idx_two;
    push_op.flags.wrap     = taken && idx_ge2;
    push_op.flags.over     = !taken;
    push_op.flags.last     = vertex.last_vertex;

    push_op.term_a  = widen(previous_x) + x;
    push_op.term_b  = widen(previous_y) - y;
    push_op.close_a = x + fx;
    push_op.close_b = y - fy;

    // Triple (older, previous, new).
    push_op.cm.d1x = x - widen(previous_x);
    push_op.cm.d1y = y - widen(previous_y);
    push_op.cm.d2x = widen(older_x) - widen(previous_x);
    push_op.cm.d2y = widen(older_y) - widen(previous_y);
    // Wrap triple (previous, new, first).
    push_op.w1.d1x = widen(first_x) - x;
    push_op.w1.d1y = widen(first_y) - y;
    push_op.w1.d2x = widen(previous_x) - x;
    push_op.w1.d2y = widen(previous_y) - y;
    // Wrap triple (new, first, second).
    push_op.w2.d1x = widen(second_x) - widen(first_x);
    push_op.w2.d1y = widen(second_y) - widen(first_y);
    push_op.w2.d2x = x - widen(first_x);
    push_op.w2.d2y = y - widen(first_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (push) begin
      if (vertex.last_vertex) begin
        vertex_count <= '0;
      end else if (taken) begin
        vertex_count <= vertex_count + CNT_W'(1);
      end else begin
        vertex_count <= OVER_CNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && taken) begin
      if (idx_zero) begin
        first_x <= vertex.vertex_x;
        first_y <= vertex.vertex_y;
      end
      if (idx_one) begin
        second_x <= vertex.vertex_x;
        second_y <= vertex.vertex_y;
      end
      older_x    <= previous_x;
      older_y    <= previous_y;
      previous_x <= vertex.vertex_x;
      previous_y <= vertex.vertex_y;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cpa_queue.sv
// Short FIFO of operand sets between the front end and the back end.
// Uses cpa_pkg and the assertion macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cpa_pkg::cpa_op_t push_op,
  output logic             full,
  output logic             head_valid,
  output cpa_pkg::cpa_op_t head_op,
  input  logic             pop
);
  import cpa_pkg::*;

  cpa_op_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full       = fill == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  `CPA_ASSERT_IMP(a_no_overrun, clk, rst, push, !full || pop)
  `CPA_ASSERT_IMP(a_empty_ptrs, clk, rst, fill == '0, rd_ptr == wr_ptr)

endmodule

`default_nettype wire

FILE: rtl/core/cpa_back.sv
// Back end of the convex polygon area block: products, sign tests, running
// shoelace sum, convexity tracking and the result register. Uses cpa_pkg.
`default_nettype none
`include "assert_macros.svh"

module cpa_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  cpa_pkg::cpa_op_t     head_op,
  output logic                 pop,
  output logic                 result_valid,
  output cpa_pkg::cpa_result_t result,
  input  logic                 result_stall
);
  import cpa_pkg::*;

  typedef logic signed [PROD_W:0]  tc_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  logic adv;

  logic       s1_valid;
  cpa_flags_t s1_flags;
  prod_t      s1_term, s1_close;
  prod_t      s1_cm_p, s1_cm_q, s1_w1_p, s1_w1_q, s1_w2_p, s1_w2_q;

  logic       s2_valid;
  cpa_flags_t s2_flags;
  prod_t      s2_term_add;
  tc_t        s2_tc;
  logic       s2_pos_m, s2_pos_w1, s2_pos_w2;

  logic       s3_valid;
  sum_t       s3_total;
  logic       s3_ok, s3_over;

  sum_t       shoelace_sum;
  logic       reference_sign;
  logic       convex_so_far;

  prod_t      term_gated;
  logic       ref_eff, convex_eff, ok;
  sum_t       sum_plus_term, total, mag;

  // The whole back end moves as one while the result register can load.
  assign adv = !result_valid || !result_stall;
  assign pop = adv && head_valid;

  always_comb begin
    term_gated    = s1_flags.do_term ? s1_term : '0;
    ref_eff       = s2_flags.set_ref ? s2_pos_m : reference_sign;
    convex_eff    = convex_so_far &&
                    !(s2_flags.do_cross && !s2_flags.set_ref && (s2_pos_m != reference_sign));
    ok            = convex_eff &&
                    (!s2_flags.wrap || ((s2_pos_w1 == ref_eff) && (s2_pos_w2 == ref_eff)));
    sum_plus_term = shoelace_sum + {{(SUM_W-PROD_W){s2_term_add[PROD_W-1]}}, s2_term_add};
    total         = shoelace_sum + {{(SUM_W-PROD_W-1){s2_tc[PROD_W]}}, s2_tc};
    mag           = s3_total[SUM_W-1] ? -s3_total : s3_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      result_valid   <= 1'b0;
      shoelace_sum   <= '0;
      reference_sign <= 1'b0;
      convex_so_far  <= 1'b1;
    end else if (adv) begin
      s1_valid     <= head_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid && s2_flags.last;
      result_valid <= s3_valid;
      if (s2_valid) begin
        if (s2_flags.last) begin
          shoelace_sum   <= '0;
          reference_sign <= 1'b0;
          convex_so_far  <= 1'b1;
        end else begin
          shoelace_sum   <= sum_plus_term;
          reference_sign <= ref_eff;
          convex_so_far  <= convex_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_flags <= head_op.flags;
      s1_term  <= $signed(head_op.term_a) * $signed(head_op.term_b);
      s1_close <= $signed(head_op.close_a) * $signed(head_op.close_b);
      s1_cm_p  <= $signed(head_op.cm.d1x) * $signed(head_op.cm.d2y);
      s1_cm_q  <= $signed(head_op.cm.d2x) * $signed(head_op.cm.d1y);
      s1_w1_p  <= $signed(head_op.w1.d1x) * $signed(head_op.w1.d2y);
      s1_w1_q  <= $signed(head_op.w1.d2x) * $signed(head_op.w1.d1y);
      s1_w2_p  <= $signed(head_op.w2.d1x) * $signed(head_op.w2.d2y);
      s1_w2_q  <= $signed(head_op.w2.d2x) * $signed(head_op.w2.d1y);

      s2_flags    <= s1_flags;
      s2_term_add <= term_gated;
      s2_tc       <= {term_gated[PROD_W-1], term_gated} + {s1_close[PROD_W-1], s1_close};
      s2_pos_m    <= s1_cm_p > s1_cm_q;
      s2_pos_w1   <= s1_w1_p > s1_w1_q;
      s2_pos_w2   <= s1_w2_p > s1_w2_q;

      s3_total <= total;
      s3_ok    <= ok;
      s3_over  <= s2_flags.over;

      if (s3_over) begin
        result.area_doubled <= '0;
        result.status       <= STATUS_TOO_MANY;
      end else begin
        result.area_doubled <= mag[AREA_W-1:0];
        result.status       <= (s3_ok && (s3_total != '0)) ? STATUS_VALID : STATUS_REJECTED;
      end
    end
  end

  `CPA_ASSERT_NXT(a_clear_after_last, clk, rst, adv && s2_valid && s2_flags.last, shoelace_sum == '0 && convex_so_far && !reference_sign)
  `CPA_ASSERT_NXT(a_sum_holds_idle, clk, rst, !adv || !s2_valid, $stable(shoelace_sum))

endmodule

`default_nettype wire

FILE: rtl/core/convex_polygon_area.sv
// Top level of the convex polygon area block: front end, operand queue, back end.
// Uses cpa_pkg, cpa_front, cpa_queue and cpa_back.
`default_nettype none

// Polygon vertices arrive one item per cycle, unless vertex_stall holds them,
// on the vertex channel, the last one marked by last_vertex. For each polygon
// the block returns one item on the result channel: twice the absolute area
// (the magnitude of the shoelace sum) and a status that is valid, rejected
// (the cross products of the consecutive vertex triples, wrap-around triples
// included, do not all share the first one's sign, a zero cross product
// counting as non-positive, or the area is zero), or too many vertices (more
// than MAX_VERTICES, with an area of zero). The block sustains one vertex per
// clock while vertex_stall is low, with no gap between polygons. The vertex
// lands in the operand queue at the edge that takes it, and then passes the
// multiplier stage, the sign-test stage, the accumulator stage and the result
// register. The front end forms all coordinate differences; eight multipliers
// in the back end work on each vertex at once. A four-entry queue between
// them lets the vertex side keep going while the result side is stalled,
// until the queue is full.
module convex_polygon_area #(
  parameter int unsigned MAX_VERTICES = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vertex_valid,
  input  cpa_pkg::cpa_vertex_t vertex,
  output logic                 vertex_stall,
  output logic                 result_valid,
  output cpa_pkg::cpa_result_t result,
  input  logic                 result_stall
);
  import cpa_pkg::*;

  // Operand sets travel from the front end through the queue to the back end.
  logic    queue_full;
  logic    push;
  cpa_op_t push_op;
  logic    head_valid;
  cpa_op_t head_op;
  logic    pop;

  cpa_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex       (vertex),
    .vertex_stall (vertex_stall),
    .queue_full   (queue_full),
    .push         (push),
    .push_op      (push_op)
  );

  cpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  cpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

FILE: dv/convex_polygon_area_tb.sv
// Testbench for convex_polygon_area: directed table and random polygons.
// Checks every result item against a built-in shoelace and convexity predictor
// or a typed row's result. Depends on cpa_pkg and the convex_polygon_area RTL.
`timescale 1ns / 1ps

module convex_polygon_area_tb;
  import cpa_pkg::*;

  localparam int unsigned MAX_VERTICES   = 65535;
  localparam int          RANDOM_ITEMS   = 500;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 20;

  // One row of the directed table. When typed is set, the expected result of
  // the polygon that the row closes is the one written in the row.
  typedef struct packed {
    cpa_vertex_t v;
    logic        typed;
    cpa_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        vertex_valid = 1'b0;
  cpa_vertex_t vertex       = '0;
  logic        vertex_stall;
  logic        result_valid;
  cpa_result_t result;
  logic        result_stall = 1'b0;

  // Typed expectation that travels with the vertex item on the channel.
  logic        row_typed  = 1'b0;
  cpa_result_t row_result = '0;

  cpa_result_t areas_due [$];
  cpa_vertex_t shape [$];
  stim_row_t   directed_rows [25];
  int          errors      = 0;
  int          quiet_count = 0;
  bit          quiet_phase = 1'b0;

  // Predictor state for the polygon being collected.
  coord_t      pf_x, pf_y, ps_x, ps_y, po_x, po_y, pp_x, pp_y;
  longint      run_sum;
  bit          ref_pos;
  bit          convex_ok;
  int unsigned taken;

  convex_polygon_area #(
    .MAX_VERTICES(MAX_VERTICES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex       (vertex),
    .vertex_stall (vertex_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // True when the cross product of the triple (a, b, c) is strictly positive.
  // Differences are 17 bits and products 34 bits, so 64-bit math is exact.
  function automatic bit cross_above_zero(longint ax, longint ay, longint bx, longint by,
                                          longint cx, longint cy);
    longint d1x, d1y, d2x, d2y;
    d1x = cx - bx;
    d1y = cy - by;
    d2x = ax - bx;
    d2y = ay - by;
    return (d1x * d2y) > (d2x * d1y);
  endfunction

  function automatic longint edge_term(longint ax, longint ay, longint bx, longint by);
    return (ax + bx) * (ay - by);
  endfunction

  task automatic clear_polygon();
    pf_x = '0; pf_y = '0; ps_x = '0; ps_y = '0;
    po_x = '0; po_y = '0; pp_x = '0; pp_y = '0;
    run_sum   = 0;
    ref_pos   = 1'b0;
    convex_ok = 1'b1;
    taken     = 0;
  endtask

  // Advances the predictor by one vertex; on the last vertex it returns the
  // area and status the block has to produce and starts a new polygon.
  task automatic predict_area(input cpa_vertex_t v, output bit emits,
                              output cpa_result_t r);
    longint closed, mag;
    bit     pos, ok;
    emits = 1'b0;
    r     = '0;
    if (taken < MAX_VERTICES) begin
      if (taken == 0) begin
        pf_x = v.vertex_x;
        pf_y = v.vertex_y;
      end
      if (taken == 1) begin
        ps_x = v.vertex_x;
        ps_y = v.vertex_y;
      end
      if (taken >= 1) run_sum += edge_term(pp_x, pp_y, v.vertex_x, v.vertex_y);
      if (taken >= 2) begin
        pos = cross_above_zero(po_x, po_y, pp_x, pp_y, v.vertex_x, v.vertex_y);
        if (taken == 2) ref_pos = pos;
        else if (pos != ref_pos) convex_ok = 1'b0;
      end
      po_x  = pp_x;
      po_y  = pp_y;
      pp_x  = v.vertex_x;
      pp_y  = v.vertex_y;
      taken = taken + 1;
    end else begin
      taken = MAX_VERTICES + 1;
    end

    if (v.last_vertex) begin
      emits = 1'b1;
      if (taken > MAX_VERTICES) begin
        r.area_doubled = '0;
        r.status       = STATUS_TOO_MANY;
      end else begin
        ok     = convex_ok;
        closed = run_sum + edge_term(pp_x, pp_y, pf_x, pf_y);
        if (taken >= 3) begin
          // The two triples that wrap round through the first two vertices.
          if (cross_above_zero(po_x, po_y, pp_x, pp_y, pf_x, pf_y) != ref_pos) ok = 1'b0;
          if (cross_above_zero(pp_x, pp_y, pf_x, pf_y, ps_x, ps_y) != ref_pos) ok = 1'b0;
        end
        mag            = (closed < 0) ? -closed : closed;
        r.area_doubled = mag[AREA_W-1:0];
        r.status       = (ok && closed != 0) ? STATUS_VALID : STATUS_REJECTED;
      end
      clear_polygon();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted vertex item and checks each accepted
  // result item against the oldest expectation. All signals are read at the
  // rising edge, before any nonblocking update of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bit          emits;
    cpa_result_t predicted;
    cpa_result_t want;
    if (!rst) begin
      if (vertex_valid && !vertex_stall) begin
        predict_area(vertex, emits, predicted);
        if (emits) areas_due.push_back(row_typed ? row_result : predicted);
      end
      if (result_valid && !result_stall) begin
        if (areas_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, expected none, got area %0d status %0d",
                   $time, result.area_doubled, result.status);
        end else begin
          want = areas_due.pop_front();
          if (result.area_doubled !== want.area_doubled) begin
            errors++;
            $display("%0t: area_doubled mismatch, expected %0d, got %0d",
                     $time, want.area_doubled, result.area_doubled);
          end
          if (result.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, result.status);
          end
        end
      end
    end
  end

  // The watchdog ends the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (vertex_valid && !vertex_stall) || (result_valid && !result_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait before an item on either side; zero throughout a quiet phase so that
  // the block also sees long stretches at full rate.
  function automatic int unsigned pick_wait();
    if (quiet_phase || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  function automatic stim_row_t row(int x, int y, bit last, bit typed, longint area,
                                    logic [1:0] status);
    stim_row_t s;
    s.v.vertex_x       = coord_t'(x);
    s.v.vertex_y       = coord_t'(y);
    s.v.last_vertex    = last;
    s.typed            = typed;
    s.res.area_doubled = area[AREA_W-1:0];
    s.res.status       = status;
    return s;
  endfunction

  // Orders edge vectors by angle: upper half plane first, then by cross product.
  function automatic bit angle_before(longint ax, longint ay, longint bx, longint by);
    bit ha, hb;
    ha = (ay < 0) || (ay == 0 && ax < 0);
    hb = (by < 0) || (by == 0 && bx < 0);
    if (ha != hb) return ha < hb;
    return (ax * by - ay * bx) > 0;
  endfunction

  // Drives one vertex item after a gap and holds it until it is accepted.
  task automatic send_vertex(input cpa_vertex_t v, input int unsigned gap,
                             input logic typed, input cpa_result_t res);
    if (gap > 0) begin
      vertex_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex       <= v;
    row_typed    <= typed;
    row_result   <= res;
    @(posedge clk);
    while (vertex_stall) @(posedge clk);
  endtask

  // The sender holds off until every expected result item has come back.
  task automatic drain_results();
    vertex_valid <= 1'b0;
    @(posedge clk);
    while (areas_due.size() != 0) @(posedge clk);
  endtask

  task automatic build_noise(input int n);
    int k;
    shape = {};
    for (k = 0; k < n; k++) shape.push_back({any_coord(), any_coord(), k == n - 1});
  endtask

  // Builds a convex polygon: random edge vectors closed to a zero sum, sorted
  // by angle and chained. The start vertex, direction and offset are random.
  task automatic build_convex(input int n, input int radius);
    int ex[$], ey[$], px[$], py[$];
    int sum_x, sum_y, tx, ty, i, j, m, k, idx, rot;
    int min_x, max_x, min_y, max_y, off_x, off_y;
    bit flip;
    sum_x = 0;
    sum_y = 0;
    for (i = 0; i < n - 1; i++) begin
      do begin
        tx = int'($urandom_range(0, 2 * radius)) - radius;
        ty = int'($urandom_range(0, 2 * radius)) - radius;
      end while (tx == 0 && ty == 0);
      ex.push_back(tx);
      ey.push_back(ty);
      sum_x += tx;
      sum_y += ty;
    end
    if (sum_x != 0 || sum_y != 0) begin
      ex.push_back(-sum_x);
      ey.push_back(-sum_y);
    end
    for (i = 1; i < ex.size(); i++) begin
      j = i;
      while (j > 0 && angle_before(ex[j], ey[j], ex[j-1], ey[j-1])) begin
        tx = ex[j]; ex[j] = ex[j-1]; ex[j-1] = tx;
        ty = ey[j]; ey[j] = ey[j-1]; ey[j-1] = ty;
        j--;
      end
    end
    m = ex.size();
    tx = 0; ty = 0;
    min_x = 0; max_x = 0; min_y = 0; max_y = 0;
    for (i = 0; i < m; i++) begin
      px.push_back(tx);
      py.push_back(ty);
      if (tx < min_x) min_x = tx;
      if (tx > max_x) max_x = tx;
      if (ty < min_y) min_y = ty;
      if (ty > max_y) max_y = ty;
      tx += ex[i];
      ty += ey[i];
    end
    off_x = -32768 - min_x + int'($urandom_range(0, 65535 - (max_x - min_x)));
    off_y = -32768 - min_y + int'($urandom_range(0, 65535 - (max_y - min_y)));
    rot   = $urandom_range(0, m - 1);
    flip  = $urandom_range(0, 1);
    shape = {};
    for (k = 0; k < m; k++) begin
      idx = flip ? (rot - k + m) % m : (rot + k) % m;
      shape.push_back({coord_t'(px[idx] + off_x), coord_t'(py[idx] + off_y), k == m - 1});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stalls for a drawn number of cycles, then takes one item.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned hold;
    @(negedge rst);
    forever begin
      hold = pick_wait();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex side: directed table, then random polygons.
  // ---------------------------------------------------------------------------
  initial begin : vertex_side
    int k, n, kind, radius, sent, a, b;
    bit first_poly;
    coord_t swap_c;

    clear_polygon();

    // Single vertex straight after reset, two extreme vertices, unit square,
    // the largest square and triangle, a collinear triple with zero cross
    // products and zero area, a concave quadrilateral and a repeated vertex.
    directed_rows = '{
      row(0, 0, 1, 1, 0, STATUS_REJECTED),
      row(32767, -32768, 0, 0, 0, STATUS_VALID),
      row(-32768, 32767, 1, 1, 0, STATUS_REJECTED),
      row(0, 0, 0, 0, 0, STATUS_VALID),
      row(1, 0, 0, 0, 0, STATUS_VALID),
      row(1, 1, 0, 0, 0, STATUS_VALID),
      row(0, 1, 1, 0, 0, STATUS_VALID),
      row(-32768, -32768, 0, 0, 0, STATUS_VALID),
      row(-32768, 32767, 0, 0, 0, STATUS_VALID),
      row(32767, 32767, 0, 0, 0, STATUS_VALID),
      row(32767, -32768, 1, 0, 0, STATUS_VALID),
      row(-32768, -32768, 0, 0, 0, STATUS_VALID),
      row(32767, -32768, 0, 0, 0, STATUS_VALID),
      row(32767, 32767, 1, 0, 0, STATUS_VALID),
      row(0, 0, 0, 0, 0, STATUS_VALID),
      row(1, 1, 0, 0, 0, STATUS_VALID),
      row(2, 2, 1, 1, 0, STATUS_REJECTED),
      row(0, 0, 0, 0, 0, STATUS_VALID),
      row(4, 0, 0, 0, 0, STATUS_VALID),
      row(1, 1, 0, 0, 0, STATUS_VALID),
      row(0, 4, 1, 0, 0, STATUS_VALID),
      row(0, 0, 0, 0, 0, STATUS_VALID),
      row(0, 0, 0, 0, 0, STATUS_VALID),
      row(5, 0, 0, 0, 0, STATUS_VALID),
      row(5, 5, 1, 0, 0, STATUS_VALID)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k])
      send_vertex(directed_rows[k].v, pick_wait(), directed_rows[k].typed,
                  directed_rows[k].res);

    // Random polygons, in a random mix: mostly convex ones, some convex ones with
    // one vertex moved or two vertices swapped, and noise.
    sent       = 0;
    first_poly = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      k    = $urandom_range(0, 19);
      if (k < 14)      n = $urandom_range(3, 8);
      else if (k < 17) n = $urandom_range(9, 24);
      else if (k < 19) n = $urandom_range(1, 2);
      else             n = $urandom_range(25, 60);
      k = $urandom_range(0, 3);
      if (k < 2)       radius = 60000 / n;
      else if (k == 2) radius = $urandom_range(1, 8);
      else             radius = $urandom_range(1, 1000);

      if (kind < 6 && n >= 3) begin
        build_convex(n, radius);
      end else if (kind < 8 && n >= 4) begin
        build_convex(n, radius);
        a = $urandom_range(0, shape.size() - 1);
        b = $urandom_range(0, shape.size() - 1);
        if ($urandom_range(0, 1)) begin
          shape[a].vertex_x = any_coord();
          shape[a].vertex_y = any_coord();
        end else begin
          swap_c = shape[a].vertex_x;
          shape[a].vertex_x = shape[b].vertex_x;
          shape[b].vertex_x = swap_c;
          swap_c = shape[a].vertex_y;
          shape[a].vertex_y = shape[b].vertex_y;
          shape[b].vertex_y = swap_c;
        end
      end else begin
        build_noise(n);
      end

      quiet_phase = ($urandom_range(0, 7) == 0);
      if (first_poly || $urandom_range(0, 9) == 0) drain_results();
      first_poly = 1'b0;
      foreach (shape[k]) send_vertex(shape[k], pick_wait(), 1'b0, '0);
      sent += shape.size();
    end
    quiet_phase = 1'b0;

    // All stimulus is in; let the last results come out and the pipe settle.
    vertex_valid <= 1'b0;
    @(posedge clk);
    while (areas_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/cpa_pkg.sv
rtl/core/cpa_front.sv
rtl/core/cpa_queue.sv
rtl/core/cpa_back.sv
rtl/core/convex_polygon_area.sv
dv/convex_polygon_area_tb.sv
